// File: hdl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared constants for the decimal text to fixed point unit
// Character codes that steer the parser and the width of the place counter.
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 3;    // fraction place counter, up to seven places
  localparam int DIGIT_W = 4;

endpackage

// File: hdl/dtf_if.sv
// ----------------------------------------------------------------------------
// dtf_if: channel interfaces
// Valid/ready channels for text bytes in and parsed numbers out.
// ----------------------------------------------------------------------------
interface dtf_char_if;
  logic                           valid;
  logic                           ready;
  logic [dtf_pkg::CHAR_W-1:0]     char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface dtf_result_if #(
  parameter int VALUE_W = 41
);
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

// File: hdl/decimal_text_to_fixed_point_unit.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_unit: ASCII decimal text to signed fixed point
// Parses a byte stream into signed Q(INT_BITS).(FRAC_BITS) numbers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one text byte per transaction. Digits, a '-' anywhere and
//   one '.' build the number; any other byte (or a second '.') ends it.
//   out_ch carries one transaction per terminating byte: the signed value
//   and a flag that is set when the magnitude saturated.
//   Throughput: one byte per cycle, set by the single accumulator update
//   between the input register and the result register, while no terminator
//   waits on a held result. A terminator passes both registers in that order.
//   Reset (rst, synchronous) empties both registers and clears the parser
//   state, so the first byte after reset starts a new number.
//   When out_ch stalls with a result held, digits and signs still advance;
//   a following terminator waits in the input register, and in_ch ready
//   drops until the result is taken. No transaction is lost or repeated.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_unit #(
  parameter int INT_BITS        = 24,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic          clk,
  input  logic          rst,
  dtf_char_if.sink      in_ch,
  dtf_result_if.source  out_ch
);

  localparam int VALUE_W = INT_BITS + FRAC_BITS + 1;

  logic                             in_valid;
  logic [dtf_pkg::CHAR_W-1:0]       in_char;
  logic                             res_valid;
  logic signed [VALUE_W-1:0]        res_value;
  logic                             res_overflow;

  logic                             is_term;
  logic signed [VALUE_W-1:0]        acc_value;
  logic                             acc_overflow;
  logic                             res_free;
  logic                             fire;

  assign res_free    = !res_valid || out_ch.ready;
  assign fire        = in_valid && (!is_term || res_free);
  assign in_ch.ready = !in_valid || fire;

  dtf_accum #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_code (in_char),
    .is_term   (is_term),
    .value     (acc_value),
    .overflow  (acc_overflow)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char <= in_ch.char_code;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= fire && is_term;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_term) begin
      res_value    <= acc_value;
      res_overflow <= acc_overflow;
    end
  end

  assign out_ch.valid    = res_valid;
  assign out_ch.value    = res_value;
  assign out_ch.overflow = res_overflow;

endmodule

// File: hdl/dtf_accum.sv
// ----------------------------------------------------------------------------
// dtf_accum: parser state and accumulator update
// Holds magnitude, sign, point and overflow state; updates it for one byte
// per cycle while fire is high and presents the signed result for a terminating byte.
// ----------------------------------------------------------------------------
module dtf_accum #(
  parameter int INT_BITS        = 24,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   fire,
  input  logic [dtf_pkg::CHAR_W-1:0]             char_code,
  output logic                                   is_term,
  output logic signed [INT_BITS+FRAC_BITS:0]     value,
  output logic                                   overflow
);

  localparam int MAG_BITS = INT_BITS + FRAC_BITS;
  localparam int NW       = INT_BITS + dtf_pkg::DIGIT_W;
  localparam int ADD_W    = FRAC_BITS + dtf_pkg::DIGIT_W;

  logic [MAG_BITS-1:0]          magnitude_acc, magnitude_acc_next;
  logic                         point_seen, point_seen_next;
  logic [dtf_pkg::POS_W-1:0]    fraction_position, fraction_position_next;
  logic                         negative_flag, negative_flag_next;
  logic                         overflow_flag, overflow_flag_next;

  logic                         is_minus, is_digit, is_point;
  logic [dtf_pkg::DIGIT_W-1:0]  digit;
  logic [NW-1:0]                int_part, int_next;
  logic [FRAC_BITS-1:0]         w_terms [MAX_FRAC_DIGITS];
  logic [FRAC_BITS-1:0]         weight;
  logic [ADD_W-1:0]             frac_add;
  logic [MAG_BITS:0]            frac_sum;
  logic [MAG_BITS:0]            mag_ext;

  // Fraction weights: round-half-up of 2^FRAC_BITS / 10^(k+1)
  for (genvar k = 0; k < MAX_FRAC_DIGITS; k++) begin : g_weight
    localparam longint unsigned P = 64'd10 ** (k + 1);
    localparam longint unsigned W = ((64'd1 << FRAC_BITS) + P / 2) / P;
    assign w_terms[k] = (fraction_position == dtf_pkg::POS_W'(k)) ?
                        FRAC_BITS'(W) : '0;
  end

  always_comb begin
    weight = '0;
    for (int k = 0; k < MAX_FRAC_DIGITS; k++) begin
      weight = weight | w_terms[k];
    end
  end

  assign is_minus = (char_code == dtf_pkg::CHAR_MINUS);
  assign is_digit = (char_code >= dtf_pkg::CHAR_ZERO) && (char_code <= dtf_pkg::CHAR_NINE);
  assign is_point = (char_code == dtf_pkg::CHAR_POINT) && !point_seen;
  assign is_term  = !is_minus && !is_digit && !is_point;
  assign digit    = dtf_pkg::DIGIT_W'(char_code - dtf_pkg::CHAR_ZERO);

  // Integer step: int * 10 + digit as two shifts and adds
  assign int_part = NW'(magnitude_acc[MAG_BITS-1:FRAC_BITS]);
  assign int_next = (int_part << 3) + (int_part << 1) + NW'(digit);

  assign frac_add = ADD_W'(digit) * ADD_W'(weight);
  assign frac_sum = {1'b0, magnitude_acc} + (MAG_BITS+1)'(frac_add);

  always_comb begin
    magnitude_acc_next     = magnitude_acc;
    point_seen_next        = point_seen;
    fraction_position_next = fraction_position;
    negative_flag_next     = negative_flag;
    overflow_flag_next     = overflow_flag;
    if (is_minus) begin
      negative_flag_next = 1'b1;
    end else if (is_digit) begin
      if (!point_seen) begin
        if (!overflow_flag) begin
          if (int_next[NW-1:INT_BITS] != '0) begin
            magnitude_acc_next = '1;
            overflow_flag_next = 1'b1;
          end else begin
            magnitude_acc_next = {int_next[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
          end
        end
      end else if (fraction_position < dtf_pkg::POS_W'(MAX_FRAC_DIGITS)) begin
        if (frac_sum[MAG_BITS]) begin
          magnitude_acc_next = '1;
          overflow_flag_next = 1'b1;
        end else begin
          magnitude_acc_next = frac_sum[MAG_BITS-1:0];
        end
        fraction_position_next = fraction_position + 1'b1;
      end
    end else if (is_point) begin
      point_seen_next = 1'b1;
    end else begin
      // terminator: clear for the next number
      magnitude_acc_next     = '0;
      point_seen_next        = 1'b0;
      fraction_position_next = '0;
      negative_flag_next     = 1'b0;
      overflow_flag_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_acc     <= '0;
      point_seen        <= 1'b0;
      fraction_position <= '0;
      negative_flag     <= 1'b0;
      overflow_flag     <= 1'b0;
    end else if (fire) begin
      magnitude_acc     <= magnitude_acc_next;
      point_seen        <= point_seen_next;
      fraction_position <= fraction_position_next;
      negative_flag     <= negative_flag_next;
      overflow_flag     <= overflow_flag_next;
    end
  end

  assign mag_ext  = {1'b0, magnitude_acc};
  assign value    = negative_flag ? $signed(-mag_ext) : $signed(mag_ext);
  assign overflow = overflow_flag;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: bench for decimal_text_to_fixed_point_unit
// Streams ASCII text into the parser and checks every parsed number against
// an in-bench parser, under three back-pressure mixes, the first two with random gaps.
// ----------------------------------------------------------------------------
module tb;

  localparam int INT_BITS        = 24;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 5;
  localparam int MAG_W           = INT_BITS + FRAC_BITS;
  localparam int VALUE_W         = MAG_W + 1;

  localparam logic [63:0]      INT_LIMIT = (64'd1 << INT_BITS) - 1;
  localparam logic [MAG_W-1:0] MAG_FULL  = '1;

  localparam int CHARS_PER_PHASE = 400;
  localparam int STALL_LIMIT     = 3000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
  } number_t;

  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dtf_char_if                         in_ch ();
  dtf_result_if #(.VALUE_W(VALUE_W))  out_ch ();

  decimal_text_to_fixed_point_unit #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // text waiting to be sent and numbers the parser still owes
  logic [7:0] text_q[$];
  number_t    owed_numbers[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int chars_sent;
  int numbers_seen;
  int saturated_seen;
  int negative_seen;
  int idle_cycles;

  // shadow parser state
  logic [MAG_W-1:0]          mag_q;
  logic                      point_q;
  logic [dtf_pkg::POS_W-1:0] places_q;
  logic                      minus_q;
  logic                      sat_q;

  // round-half-up of 2^FRAC_BITS / 10^(k+1)
  function automatic logic [63:0] place_weight(input int k);
    logic [63:0] p;
    p = 64'd10;
    for (int i = 0; i < k; i++) p = p * 10;
    return ((64'd1 << FRAC_BITS) + p / 2) / p;
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic [63:0] ipart;
    logic [63:0] add;
    number_t     num;
    if (c == dtf_pkg::CHAR_MINUS) begin
      minus_q = 1'b1;
    end else if (c >= dtf_pkg::CHAR_ZERO && c <= dtf_pkg::CHAR_NINE) begin
      if (!point_q) begin
        if (!sat_q) begin
          ipart = 64'(mag_q >> FRAC_BITS) * 64'd10 + 64'(c - dtf_pkg::CHAR_ZERO);
          if (ipart > INT_LIMIT) begin
            mag_q = MAG_FULL;
            sat_q = 1'b1;
          end else begin
            mag_q = MAG_W'(ipart << FRAC_BITS);
          end
        end
      end else if (places_q < MAX_FRAC_DIGITS) begin
        add = 64'(c - dtf_pkg::CHAR_ZERO) * place_weight(places_q);
        if (add > 64'(MAG_FULL) - 64'(mag_q)) begin
          mag_q = MAG_FULL;
          sat_q = 1'b1;
        end else begin
          mag_q = mag_q + MAG_W'(add);
        end
        places_q = places_q + 1'b1;
      end
    end else if (c == dtf_pkg::CHAR_POINT && !point_q) begin
      point_q = 1'b1;
    end else begin
      // terminator: emit and start over
      num.value = {1'b0, mag_q};
      if (minus_q) num.value = -num.value;
      num.overflow = sat_q;
      owed_numbers.push_back(num);
      mag_q    = '0;
      point_q  = 1'b0;
      places_q = '0;
      minus_q  = 1'b0;
      sat_q    = 1'b0;
    end
  endtask

  function automatic logic [7:0] random_stop();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == dtf_pkg::CHAR_MINUS || c == dtf_pkg::CHAR_POINT ||
               (c >= dtf_pkg::CHAR_ZERO && c <= dtf_pkg::CHAR_NINE));
    return c;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // one well-formed number with random content, signs scattered anywhere
  task automatic add_number();
    logic [7:0] word[$];
    string      top;
    int         n_int;
    int         n_frac;
    int         d;
    bit         has_point;
    top = "16777215";
    if ($urandom_range(0, 7) == 0) begin
      for (int i = 0; i < top.len(); i++) word.push_back(top[i]);
    end else begin
      n_int = $urandom_range(0, 10);
      for (int i = 0; i < n_int; i++) begin
        word.push_back(dtf_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    has_point = ($urandom_range(0, 3) != 0);
    if (has_point) begin
      word.push_back(dtf_pkg::CHAR_POINT);
      n_frac = $urandom_range(0, 7);
      for (int i = 0; i < n_frac; i++) begin
        d = ($urandom_range(0, 3) == 0) ? 9 : $urandom_range(0, 9);
        word.push_back(dtf_pkg::CHAR_ZERO + 8'(d));
      end
    end
    repeat ($urandom_range(0, 2)) begin
      word.insert($urandom_range(0, word.size()), dtf_pkg::CHAR_MINUS);
    end
    if (has_point && $urandom_range(0, 4) == 0) word.push_back(dtf_pkg::CHAR_POINT);
    else word.push_back(random_stop());
    foreach (word[i]) text_q.push_back(word[i]);
  endtask

  // driver: one transaction per cycle at most, random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_char(in_ch.char_code);
        chars_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (text_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.char_code <= text_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each number with the oldest one owed
  always @(posedge clk) begin
    number_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        numbers_seen++;
        if (out_ch.overflow) saturated_seen++;
        if (out_ch.value < 0) negative_seen++;
        if (owed_numbers.size() == 0) begin
          $error("unexpected number: value %0d overflow %0b", out_ch.value, out_ch.overflow);
          errors++;
        end else begin
          want = owed_numbers.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.value);
            errors++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_ch.overflow);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(1, 100) > recv_idle_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    out_ch.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    errors          = 0;
    chars_sent      = 0;
    numbers_seen    = 0;
    saturated_seen  = 0;
    negative_seen   = 0;
    idle_cycles     = 0;
    mag_q           = '0;
    point_q         = 1'b0;
    places_q        = '0;
    minus_q         = 1'b0;
    sat_q           = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        text_q.push_back(8'h00);        // terminator with nothing before it
        push_text("--7..");             // repeated minus, second point ends it
        push_text("999999999");         // integer saturation
        text_q.push_back(8'hFF);
        push_text(".999999:");          // places past the limit are dropped
      end
      while (text_q.size() < CHARS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(0, 255)));
        else add_number();
      end
      text_q.push_back(random_stop());
      // hold off until the phase has fully drained
      do @(negedge clk);
      while (text_q.size() != 0 || in_ch.valid || owed_numbers.size() != 0);
    end

    repeat (8) @(posedge clk);
    $display("tb: %0d chars sent, %0d numbers checked (%0d saturated, %0d negative)",
             chars_sent, numbers_seen, saturated_seen, negative_seen);
    $display("tb: three stall mixes run, each drained before the next");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
